@@ sv/assert_macros.svh @@
// Assertion helpers: active in simulation, empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is asserted (active low).
`define KWM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Condition that must never hold out of reset.
`define KWM_NEVER(label, clk, rst_n, cond) \
  `KWM_ASSERT(label, clk, rst_n, !(cond))

`else

`define KWM_ASSERT(label, clk, rst_n, prop)
`define KWM_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ sv/kwm_pkg.sv @@
`default_nettype none

package kwm_pkg;

  localparam int LANES       = 8;
  localparam int VALUE_BITS  = 32;
  localparam int LANE_BITS   = $clog2(LANES);
  localparam int CNT_BITS    = 4;
  localparam int TREE_LVL    = $clog2(LANES);
  localparam int TREE_LEAVES = 1 << TREE_LVL;
  localparam int TREE_NODES  = 2 * TREE_LEAVES - 1;

  localparam logic [CNT_BITS-1:0] ACTIVE_RESET = CNT_BITS'(LANES);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [LANE_BITS-1:0]         lane_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic [LANES-1:0]             lane_mask_t;

  // One result item.
  typedef struct packed {
    value_t     merged_value;
    lane_t      source_lane;
    logic       end_of_merge;
    logic       protocol_error;
  } res_t;

endpackage

`default_nettype wire

@@ sv/kwm_min_tree.sv @@
`default_nettype none

// Argmin over lane heads, binary tree; ties go to the lower lane.
module kwm_min_tree
  import kwm_pkg::*;
(
  input  wire lane_mask_t cand,
  input  wire value_t     val [LANES],
  output logic            found,
  output lane_t           best,
  output value_t          min_val
);

  logic   nd_vld [TREE_NODES];
  value_t nd_val [TREE_NODES];
  lane_t  nd_idx [TREE_NODES];

  for (genvar j = 0; j < TREE_LEAVES; j++) begin : g_leaf
    if (j < LANES) begin : g_real
      assign nd_vld[TREE_LEAVES-1+j] = cand[j];
      assign nd_val[TREE_LEAVES-1+j] = val[j];
    end else begin : g_pad
      assign nd_vld[TREE_LEAVES-1+j] = 1'b0;
      assign nd_val[TREE_LEAVES-1+j] = '0;
    end
    assign nd_idx[TREE_LEAVES-1+j] = LANE_BITS'(j);
  end

  for (genvar k = 0; k < TREE_LEAVES - 1; k++) begin : g_node
    logic take_left;
    // left child holds the lower lanes, so it wins ties
    assign take_left = nd_vld[2*k+1] &&
                       (!nd_vld[2*k+2] || (nd_val[2*k+1] <= nd_val[2*k+2]));
    assign nd_vld[k] = nd_vld[2*k+1] | nd_vld[2*k+2];
    assign nd_val[k] = take_left ? nd_val[2*k+1] : nd_val[2*k+2];
    assign nd_idx[k] = take_left ? nd_idx[2*k+1] : nd_idx[2*k+2];
  end

  assign found   = nd_vld[0];
  assign best    = nd_idx[0];
  assign min_val = nd_val[0];

endmodule

`default_nettype wire

@@ sv/kwm_lanes.sv @@
`default_nettype none

// Per-lane head slots and done flags; applies one item per go cycle.
module kwm_lanes
  import kwm_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         go,
  input  wire lane_t  lane,
  input  wire value_t element,
  input  wire         lane_done,
  input  wire cnt_t   act_n,
  output logic        res_vld,
  output res_t        res
);

  value_t     head_val_r [LANES];
  lane_mask_t head_vld_r, head_vld_nxt;
  lane_mask_t fin_r, fin_nxt;

  lane_mask_t act_mask, sel_in, sel_best, vld_post, fin_post, cand;
  value_t     val_view [LANES];
  logic       err, wr_head, wr_fin, ready, found;
  lane_t      best;
  value_t     min_val;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      act_mask[i] = int'(act_n) > i;
      sel_in[i]   = lane == LANE_BITS'(i);
    end
  end

  assign err     = ~act_mask[lane] | head_vld_r[lane] | fin_r[lane];
  assign wr_head = go & ~err & ~lane_done;
  assign wr_fin  = go & ~err & lane_done;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      vld_post[i] = head_vld_r[i] | (wr_head & sel_in[i]);
      fin_post[i] = fin_r[i] | (wr_fin & sel_in[i]);
      val_view[i] = (wr_head && sel_in[i]) ? element : head_val_r[i];
    end
  end

  assign cand  = vld_post & act_mask;
  assign ready = &(vld_post | fin_post | ~act_mask);

  kwm_min_tree u_tree (
    .cand    (cand),
    .val     (val_view),
    .found   (found),
    .best    (best),
    .min_val (min_val)
  );

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sel_best[i] = best == LANE_BITS'(i);
    end
    head_vld_nxt = vld_post;
    fin_nxt      = fin_post;
    if (go && ready) begin
      if (found) begin
        head_vld_nxt = vld_post & ~sel_best;
      end else begin
        fin_nxt = '0;
      end
    end
  end

  assign res_vld            = go & (err | ready);
  assign res.merged_value   = (ready && found) ? min_val : '0;
  assign res.source_lane    = (ready && found) ? best : '0;
  assign res.end_of_merge   = ready & ~found;
  assign res.protocol_error = err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= '0;
      fin_r      <= '0;
    end else begin
      head_vld_r <= head_vld_nxt;
      fin_r      <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_head) begin
      head_val_r[lane] <= element;
    end
  end

endmodule

`default_nettype wire

@@ sv/kwm_out_q.sv @@
`default_nettype none
`include "assert_macros.svh"

// Result register plus one skid entry.
module kwm_out_q
  import kwm_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        push,
  input  wire res_t  push_res,
  output logic       full,
  output logic       out_valid,
  input  wire        out_stall,
  output res_t       out_res
);

  logic out_vld_r, out_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;
  logic take;

  assign take = out_vld_r & ~out_stall;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_res_nxt  = out_res_r;
    skid_res_nxt = skid_res_r;
    if (skid_vld_r) begin
      if (take) begin
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || take) begin
        out_res_nxt = push_res;
        out_vld_nxt = 1'b1;
      end else begin
        skid_res_nxt = push_res;
        skid_vld_nxt = 1'b1;
      end
    end else if (take) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  `KWM_NEVER(a_skid_without_out, clk, rst_n, skid_vld_r && !out_vld_r)
  `KWM_NEVER(a_push_when_full, clk, rst_n, push && skid_vld_r)
  `KWM_ASSERT(a_skid_holds, clk, rst_n, (skid_vld_r && out_stall) |=> skid_vld_r)
  `KWM_ASSERT(a_held_push_to_skid, clk, rst_n, (push && out_vld_r && out_stall) |=> skid_vld_r)

endmodule

`default_nettype wire

@@ sv/k_way_merge_of_sorted_streams.sv @@
`default_nettype none

// K-way merge of up to eight ascending signed 32-bit streams. Each input
// transfer either delivers the next element of one lane or marks that lane
// exhausted (in_lane_done). Once every active lane (0 .. active_lanes-1)
// holds a head or is done, the same transfer yields the smallest head and
// its lane; ties go to the lowest lane, and the caller should then send
// that lane's next element. When all active lanes are done and drained, an
// end_of_merge result is produced (value fields zero) and all done flags
// clear, ready for the next merge. A transfer aimed at an inactive, full
// or already-done lane is dropped and flagged with protocol_error; that
// result still carries an emission if the lanes are ready. active_lanes of
// 0 acts as 1, above 8 acts as 8. Rate: one input transfer per cycle while
// in_stall is low; results go to out_*, or the skid entry under output
// stall. The lane update and three-level comparator tree over the eight
// heads are combinational. in_stall only rises when the result register
// and skid entry are full. Write cfg_active_lanes only while idle.
module k_way_merge_of_sorted_streams
  import kwm_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,

  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire cnt_t   cfg_active_lanes,

  input  wire         in_valid,
  output logic        in_stall,
  input  wire lane_t  in_lane,
  input  wire value_t in_element,
  input  wire         in_lane_done,

  output logic        out_valid,
  input  wire         out_stall,
  output value_t      out_merged_value,
  output lane_t       out_source_lane,
  output logic        out_end_of_merge,
  output logic        out_protocol_error
);

  cnt_t active_r;
  cnt_t act_n;
  logic go;
  logic res_vld;
  res_t res;
  res_t out_res;
  logic q_full;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_r <= cfg_active_lanes;
    end
  end

  // clamp the lane count to 1 .. LANES
  always_comb begin
    priority if (active_r == '0) begin
      act_n = CNT_BITS'(1);
    end else if (int'(active_r) > LANES) begin
      act_n = CNT_BITS'(LANES);
    end else begin
      act_n = active_r;
    end
  end

  assign in_stall = q_full;
  assign go       = in_valid & ~in_stall;

  kwm_lanes u_lanes (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .lane      (in_lane),
    .element   (in_element),
    .lane_done (in_lane_done),
    .act_n     (act_n),
    .res_vld   (res_vld),
    .res       (res)
  );

  // result register with skid; holds one more result under output stall
  kwm_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_res  (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_merged_value   = out_res.merged_value;
  assign out_source_lane    = out_res.source_lane;
  assign out_end_of_merge   = out_res.end_of_merge;
  assign out_protocol_error = out_res.protocol_error;

endmodule

`default_nettype wire
